### rtl/core/circular_deque_defines.svh
// assertion macros for the circular deque block
// no dependencies; included by the top level only

`ifndef CIRCULAR_DEQUE_DEFINES_SVH
`define CIRCULAR_DEQUE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CDQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("circular_deque check failed");

// next-cycle implication, checked outside reset
`define CDQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("circular_deque check failed");

`endif

### rtl/core/cdq_pkg.sv
// shared types, sizes and index helpers for the circular deque
// no dependencies; used by cdq_ctrl and circular_deque

package cdq_pkg;

   localparam int DEPTH   = 16;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int OP_W    = 3;
   localparam int DATA_W  = 8;
   localparam int REQ_W   = 16;
   localparam int RSP_W   = 16;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_CLEAR      = 3'd4
   } op_type;

   // what one request does, handed from the index control to the datapath
   typedef struct packed {
      logic             accepted;
      logic             is_pop;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [IDX_W-1:0] rd_addr;
      logic             empty;
      logic             full;
   } step_type;

   function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] res;
      res = (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
      return res;
   endfunction

   function automatic logic [IDX_W-1:0] wrap_prev(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] res;
      res = (idx == '0) ? LAST_IDX : idx - IDX_W'(1);
      return res;
   endfunction

endpackage

### rtl/core/cdq_ctrl.sv
// front/back index and empty flag control for the circular deque
// depends on cdq_pkg; decides each request and steers the ring memory

module cdq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  logic [cdq_pkg::OP_W-1:0] op,
   output cdq_pkg::step_type  step
);

   logic [cdq_pkg::IDX_W-1:0] front_ff, front_in;
   logic [cdq_pkg::IDX_W-1:0] back_ff, back_in;
   logic                      empty_ff, empty_in;
   logic                      full_now;

   assign full_now = !empty_ff && (cdq_pkg::wrap_next(back_ff) == front_ff);

   always_comb begin
      front_in      = front_ff;
      back_in       = back_ff;
      empty_in      = empty_ff;
      step.accepted = 1'b0;
      step.is_pop   = 1'b0;
      step.wr_en    = 1'b0;
      step.wr_addr  = front_ff;
      step.rd_addr  = front_ff;
      unique case (cdq_pkg::op_type'(op))
         cdq_pkg::OP_PUSH_FRONT: begin
            if (!full_now) begin
               if (empty_ff) begin
                  front_in = cdq_pkg::LAST_IDX;
                  back_in  = cdq_pkg::LAST_IDX;
               end else begin
                  front_in = cdq_pkg::wrap_prev(front_ff);
               end
               empty_in      = 1'b0;
               step.wr_en    = 1'b1;
               step.wr_addr  = front_in;
               step.accepted = 1'b1;
            end
         end
         cdq_pkg::OP_PUSH_BACK: begin
            if (!full_now) begin
               if (empty_ff) begin
                  front_in = '0;
                  back_in  = '0;
               end else begin
                  back_in = cdq_pkg::wrap_next(back_ff);
               end
               empty_in      = 1'b0;
               step.wr_en    = 1'b1;
               step.wr_addr  = back_in;
               step.accepted = 1'b1;
            end
         end
         cdq_pkg::OP_POP_FRONT: begin
            if (!empty_ff) begin
               step.rd_addr = front_ff;
               // last entry leaves: indices stay put
               if (front_ff == back_ff) empty_in = 1'b1;
               else front_in = cdq_pkg::wrap_next(front_ff);
               step.is_pop   = 1'b1;
               step.accepted = 1'b1;
            end
         end
         cdq_pkg::OP_POP_BACK: begin
            if (!empty_ff) begin
               step.rd_addr = back_ff;
               if (front_ff == back_ff) empty_in = 1'b1;
               else back_in = cdq_pkg::wrap_prev(back_ff);
               step.is_pop   = 1'b1;
               step.accepted = 1'b1;
            end
         end
         cdq_pkg::OP_CLEAR: begin
            front_in      = '0;
            back_in       = '0;
            empty_in      = 1'b1;
            step.accepted = 1'b1;
         end
         default: begin
            // unused codes are refused
            step.accepted = 1'b0;
         end
      endcase
      step.empty = empty_in;
      step.full  = !empty_in && (cdq_pkg::wrap_next(back_in) == front_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         empty_ff <= 1'b1;
      end else if (fire) begin
         front_ff <= front_in;
         back_ff  <= back_in;
         empty_ff <= empty_in;
      end
   end

endmodule

### rtl/core/circular_deque.sv
// circular deque of bytes: a ring memory with front and back indices.
// req channel: tdata[2:0] operation (0 push front, 1 push back, 2 pop front,
//   3 pop back, 4 clear), tdata[10:3] push value; other codes are refused.
// rsp channel: one transaction per request, tdata[0] accepted,
//   tdata[8:1] popped byte (zero unless a pop was done), tdata[9] empty,
//   tdata[10] full, both flags as they stand after the operation.
// the result is registered and is valid in the cycle after the request is taken.
// throughput: one request per cycle while results are taken; indices are updated in
//   the cycle the request is taken and the ring memory is read or written at that
//   edge, so the synchronous read of the next pop already sees the last push.
// a full-deque push or empty-deque pop is refused and changes nothing.
// reset empties the deque and drops any pending result; the ring memory
//   keeps its contents, which are never read before being written again.
// when rsp_tready is low a pending result holds and req_tready drops,
//   so the block takes no new request until the result is taken.
// depends on cdq_pkg, cdq_ctrl and circular_deque_defines.svh

`include "circular_deque_defines.svh"

module circular_deque (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [cdq_pkg::REQ_W-1:0] req_tdata,  // operation[2:0], push_value[10:3]
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [cdq_pkg::RSP_W-1:0] rsp_tdata   // accepted[0], pop_value[8:1],
                                                 // is_empty[9], is_full[10]
);

   logic                       fire;
   cdq_pkg::step_type          step;
   logic [cdq_pkg::DATA_W-1:0] ring_mem [cdq_pkg::DEPTH];
   logic [cdq_pkg::DATA_W-1:0] rd_data_ff;
   logic [cdq_pkg::DATA_W-1:0] push_value;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic                       accepted_ff;
   logic                       pop_ff;
   logic                       empty_ff;
   logic                       full_ff;
   logic [cdq_pkg::DATA_W-1:0] pop_value;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign fire       = req_tvalid && req_tready;
   assign push_value = req_tdata[cdq_pkg::OP_W +: cdq_pkg::DATA_W];

   cdq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .op    (req_tdata[cdq_pkg::OP_W-1:0]),
      .step  (step)
   );

   always_ff @(posedge clock) begin
      if (fire && step.wr_en) begin
         ring_mem[step.wr_addr] <= push_value;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rd_data_ff <= ring_mem[step.rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         accepted_ff <= step.accepted;
         pop_ff      <= step.is_pop;
         empty_ff    <= step.empty;
         full_ff     <= step.full;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign pop_value  = pop_ff ? rd_data_ff : '0;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(cdq_pkg::RSP_W - cdq_pkg::DATA_W - 3)'(0),
                        full_ff, empty_ff, pop_value, accepted_ff};

   `CDQ_ASSERT_NOW(a_stall_blocks_req, clock, reset, rsp_valid_ff && !rsp_tready, !req_tready)
   `CDQ_ASSERT_NOW(a_flags_exclusive, clock, reset, rsp_valid_ff, !(empty_ff && full_ff))
   `CDQ_ASSERT_NOW(a_pop_implies_ok, clock, reset, rsp_valid_ff && pop_ff, accepted_ff && !full_ff)
   `CDQ_ASSERT_NEXT(a_clear_empties, clock, reset, fire && (req_tdata[cdq_pkg::OP_W-1:0] == cdq_pkg::OP_CLEAR), rsp_valid_ff && accepted_ff && empty_ff)

endmodule

### tb/sv/circular_deque_checker.sv
`timescale 1ns / 1ps
// response checker for circular_deque: watches both stream channels, predicts
// every response from its own ring and indices, and counts mismatches
// depends on cdq_pkg for sizes and operation codes

module circular_deque_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [cdq_pkg::REQ_W-1:0] req_tdata,  // operation[2:0], push_value[10:3]
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [cdq_pkg::RSP_W-1:0] rsp_tdata,  // accepted[0], pop_value[8:1],
                                                 // is_empty[9], is_full[10]
   output int                        error_count,
   output int                        outstanding
);

   typedef struct packed {
      logic       accepted;
      logic [7:0] pop_value;
      logic       is_empty;
      logic       is_full;
   } deque_status_type;

   logic [cdq_pkg::DATA_W-1:0] ring [cdq_pkg::DEPTH];
   int unsigned                front_pos;
   int unsigned                back_pos;
   logic                       holds_none;
   deque_status_type           status_q [$];

   function automatic int unsigned ring_fwd(input int unsigned i);
      return (i + 1 >= cdq_pkg::DEPTH) ? 0 : i + 1;
   endfunction

   function automatic int unsigned ring_rev(input int unsigned i);
      return (i == 0) ? cdq_pkg::DEPTH - 1 : i - 1;
   endfunction

   function automatic logic ring_full();
      return !holds_none && (ring_fwd(back_pos) == front_pos);
   endfunction

   // applies one operation to the local deque and returns the status it yields
   function automatic deque_status_type apply_deque_op(input logic [cdq_pkg::OP_W-1:0] op,
                                                       input logic [7:0] val);
      deque_status_type st;
      st = '0;
      case (op)
         cdq_pkg::OP_PUSH_FRONT: begin
            if (!ring_full()) begin
               if (holds_none) begin
                  front_pos = cdq_pkg::DEPTH - 1;
                  back_pos  = front_pos;
               end else begin
                  front_pos = ring_rev(front_pos);
               end
               ring[front_pos] = val;
               holds_none  = 1'b0;
               st.accepted = 1'b1;
            end
         end
         cdq_pkg::OP_PUSH_BACK: begin
            if (!ring_full()) begin
               if (holds_none) begin
                  front_pos = 0;
                  back_pos  = 0;
               end else begin
                  back_pos = ring_fwd(back_pos);
               end
               ring[back_pos] = val;
               holds_none  = 1'b0;
               st.accepted = 1'b1;
            end
         end
         cdq_pkg::OP_POP_FRONT: begin
            if (!holds_none) begin
               st.pop_value = ring[front_pos];
               if (front_pos == back_pos) holds_none = 1'b1;
               else front_pos = ring_fwd(front_pos);
               st.accepted = 1'b1;
            end
         end
         cdq_pkg::OP_POP_BACK: begin
            if (!holds_none) begin
               st.pop_value = ring[back_pos];
               if (front_pos == back_pos) holds_none = 1'b1;
               else back_pos = ring_rev(back_pos);
               st.accepted = 1'b1;
            end
         end
         cdq_pkg::OP_CLEAR: begin
            holds_none  = 1'b1;
            front_pos   = 0;
            back_pos    = 0;
            st.accepted = 1'b1;
         end
         default: ;  // spare codes are refused and leave the state alone
      endcase
      st.is_empty = holds_none;
      st.is_full  = ring_full();
      return st;
   endfunction

   function automatic int field_mismatch(input string field, input logic [7:0] want,
                                         input logic [7:0] got);
      if (got !== want) begin
         $display("%0t circular_deque_checker: %s expected %0h actual %0h",
                  $time, field, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      deque_status_type want;
      deque_status_type got;
      int               delta;
      int               bad;
      if (reset) begin
         front_pos  = 0;
         back_pos   = 0;
         holds_none = 1'b1;
         status_q.delete();
         outstanding <= 0;
         error_count <= 0;
      end else begin
         delta = 0;
         bad   = 0;
         if (rsp_tvalid && rsp_tready) begin
            got.accepted  = rsp_tdata[0];
            got.pop_value = rsp_tdata[8:1];
            got.is_empty  = rsp_tdata[9];
            got.is_full   = rsp_tdata[10];
            if (status_q.size() == 0) begin
               $display("%0t circular_deque_checker: response with none expected, actual %0h",
                        $time, rsp_tdata);
               bad++;
            end else begin
               want = status_q[0];
               status_q.delete(0);
               bad += field_mismatch("accepted", 8'(want.accepted), 8'(got.accepted));
               bad += field_mismatch("pop_value", want.pop_value, got.pop_value);
               bad += field_mismatch("is_empty", 8'(want.is_empty), 8'(got.is_empty));
               bad += field_mismatch("is_full", 8'(want.is_full), 8'(got.is_full));
               delta--;
            end
         end
         if (req_tvalid && req_tready) begin
            status_q.insert(status_q.size(), apply_deque_op(req_tdata[2:0], req_tdata[10:3]));
            delta++;
         end
         outstanding <= outstanding + delta;
         error_count <= error_count + bad;
      end
   end

endmodule

### tb/sv/tb.sv
`timescale 1ns / 1ps
// top of the circular_deque testbench: clock, reset, request stimulus and
// response back-pressure; depends on cdq_pkg and circular_deque_checker

module tb;

   localparam logic [cdq_pkg::OP_W-1:0] OP_SPARE_5 = 3'd5;
   localparam logic [cdq_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [cdq_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;
   localparam int ITEMS_PER_PHASE = 150;

   typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED, MODE_NOISE} burst_mode_type;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   logic [cdq_pkg::REQ_W-1:0] req_tdata;   // operation[2:0], push_value[10:3]
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   logic [cdq_pkg::RSP_W-1:0] rsp_tdata;   // accepted[0], pop_value[8:1],
                                           // is_empty[9], is_full[10]
   int                        error_count;
   int                        outstanding;
   int                        send_idle_pct;
   int                        recv_stall_pct;

   circular_deque dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   circular_deque_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .error_count (error_count),
      .outstanding (outstanding)
   );

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   task automatic send_req(input logic [cdq_pkg::OP_W-1:0] op, input logic [7:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= cdq_pkg::REQ_W'({val, op});
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic hold_until_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   function automatic logic [cdq_pkg::OP_W-1:0] pick_op(input burst_mode_type mode);
      int roll;
      roll = $urandom_range(99);
      case (mode)
         MODE_FILL: begin
            if (roll < 85) return roll[0] ? cdq_pkg::OP_PUSH_FRONT : cdq_pkg::OP_PUSH_BACK;
            return roll[0] ? cdq_pkg::OP_POP_FRONT : cdq_pkg::OP_POP_BACK;
         end
         MODE_DRAIN: begin
            if (roll < 85) return roll[0] ? cdq_pkg::OP_POP_FRONT : cdq_pkg::OP_POP_BACK;
            return roll[0] ? cdq_pkg::OP_PUSH_FRONT : cdq_pkg::OP_PUSH_BACK;
         end
         MODE_MIXED: begin
            if (roll < 24) return cdq_pkg::OP_PUSH_FRONT;
            if (roll < 48) return cdq_pkg::OP_PUSH_BACK;
            if (roll < 72) return cdq_pkg::OP_POP_FRONT;
            if (roll < 96) return cdq_pkg::OP_POP_BACK;
            return cdq_pkg::OP_CLEAR;
         end
         default: return 3'($urandom_range(7));  // any code, spare ones included
      endcase
   endfunction

   initial begin
      burst_mode_type mode;
      int             burst_left;
      int             roll;
      int             n;
      reset          = 1'b1;
      req_tvalid     = 1'b0;
      req_tdata      = '0;
      send_idle_pct  = 14;
      recv_stall_pct = 59;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: refusals on empty, pushes into empty, last-entry pops, clear
      send_req(OP_SPARE_5, 8'hff);
      send_req(OP_SPARE_6, 8'h00);
      send_req(cdq_pkg::OP_POP_FRONT, 8'h00);
      send_req(cdq_pkg::OP_POP_BACK, 8'hff);
      send_req(cdq_pkg::OP_CLEAR, 8'h00);
      send_req(cdq_pkg::OP_PUSH_FRONT, 8'h00);
      send_req(cdq_pkg::OP_PUSH_BACK, 8'hff);
      send_req(cdq_pkg::OP_PUSH_FRONT, 8'haa);
      send_req(OP_SPARE_7, 8'h55);
      send_req(cdq_pkg::OP_POP_BACK, 8'h00);
      send_req(cdq_pkg::OP_POP_FRONT, 8'h00);
      send_req(cdq_pkg::OP_POP_FRONT, 8'hff);
      send_req(cdq_pkg::OP_POP_BACK, 8'h00);
      send_req(cdq_pkg::OP_PUSH_BACK, 8'h55);
      send_req(cdq_pkg::OP_POP_BACK, 8'h00);
      send_req(cdq_pkg::OP_PUSH_FRONT, 8'h5a);
      send_req(cdq_pkg::OP_PUSH_BACK, 8'h81);
      send_req(cdq_pkg::OP_CLEAR, 8'hff);
      send_req(cdq_pkg::OP_POP_FRONT, 8'h00);
      send_req(cdq_pkg::OP_PUSH_BACK, 8'h7e);
      send_req(cdq_pkg::OP_POP_FRONT, 8'h00);

      // random bursts; the first one is a fill burst of 22 requests, more than the deque holds
      mode       = MODE_FILL;
      burst_left = 22;
      for (n = 0; n < 3 * ITEMS_PER_PHASE; n++) begin
         if (n % ITEMS_PER_PHASE == 0) begin
            hold_until_drained();
            case (n / ITEMS_PER_PHASE)
               0: begin
                  send_idle_pct  = 14;
                  recv_stall_pct = 59;
               end
               1: begin
                  send_idle_pct  = 59;
                  recv_stall_pct = 14;
               end
               default: begin
                  send_idle_pct  = 0;
                  recv_stall_pct = 0;
               end
            endcase
         end
         if (burst_left == 0) begin
            roll = $urandom_range(99);
            if (roll < 35) mode = MODE_FILL;
            else if (roll < 65) mode = MODE_DRAIN;
            else if (roll < 93) mode = MODE_MIXED;
            else mode = MODE_NOISE;
            burst_left = $urandom_range(24, 4);
         end
         burst_left--;
         send_req(pick_op(mode), 8'($urandom_range(255)));
      end

      hold_until_drained();
      recv_stall_pct = 0;
      repeat (8) @(posedge clock);
      if (error_count == 0 && outstanding == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

   initial begin
      #200000;
      $display("tb: FAIL");
      $finish;
   end

endmodule

### circular_deque.f
+incdir+rtl/core
rtl/core/cdq_pkg.sv
rtl/core/cdq_ctrl.sv
rtl/core/circular_deque.sv
tb/sv/circular_deque_checker.sv
tb/sv/tb.sv
